// ----- design/msdp_pkg.sv -----
package msdp_pkg;

	localparam int LEVELS = 7;
	localparam int FRAC_BITS = 28;

	localparam int MAXB = (FRAC_BITS - 1 > 31) ? FRAC_BITS - 1 : 31;
	localparam int CW = MAXB + 5;
	localparam int OW = CW - 1;
	localparam int XW = ((FRAC_BITS > 32) ? FRAC_BITS : 32) + 1;
	localparam int LW = (LEVELS > 2) ? $clog2(LEVELS) : 1;

	localparam int BOX_STAGES = 3;
	localparam int LVL_STAGES = 2 * (LEVELS - 1);
	localparam int DIV_STAGES = LEVELS - 1;
	localparam int NUM_STAGES = BOX_STAGES + LVL_STAGES + DIV_STAGES;

	localparam logic signed [CW-1:0] HALF_C = CW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FRAC_BITS);
	localparam logic signed [CW-1:0] THREE_HALF_C = CW'(64'd3 << (FRAC_BITS - 1));
	localparam logic [FRAC_BITS-1:0] RECIP3 = FRAC_BITS'((64'd1 << FRAC_BITS) / 3);
	localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

	typedef logic [LW-1:0] lvl_t;

	typedef struct {
		logic signed [CW-1:0] c [4];
		logic [OW-1:0] ov [4];
		logic [3:0] viol;
		logic [FRAC_BITS-1:0] r [4];
		logic [FRAC_BITS-1:0] gap [4];
		logic [3:0] hole;
		logic done;
		logic solid;
		logic [31:0] odist;
		logic [FRAC_BITS-1:0] hdist;
		lvl_t lvl;
	} stage_t;

endpackage

// ----- design/menger_sponge_distance_probe_unit.sv -----
// Menger sponge distance probe.
// Input channel: in_valid / in_ready carry one point (pos_x, pos_y, pos_z),
// signed fixed point with msdp_pkg::FRAC_BITS fractional bits.
// Output channel: out_valid / out_ready carry one result per point:
// inside_solid and distance_estimate (unsigned, same fractional bits,
// saturating at all ones, zero for a solid point).
// The pipeline has three box stages, two stages per hole level and one
// divide-by-three stage per hole level.
// Throughput: one point per cycle while out_ready is high; every stage holds
// one point and the per-level digit step and the divide-by-three multiplier
// are each one stage.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver stalls, the held result stays on the outputs and earlier
// stages keep moving into empty slots; in_ready drops only once every stage
// is full. in_ready is high whenever out_ready is high.
module menger_sponge_distance_probe_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               inside_solid,
	output logic [31:0]        distance_estimate
);

	localparam int N = msdp_pkg::NUM_STAGES;
	localparam int FB = msdp_pkg::FRAC_BITS;
	localparam int OW = msdp_pkg::OW;
	localparam int CW = msdp_pkg::CW;
	localparam int XW = msdp_pkg::XW;

	msdp_pkg::stage_t item_s [N];
	logic [N-1:0]     vld_s;
	logic [N:0]       adv;

	function automatic logic [OW:0] pick(logic [OW:0] a, logic [OW:0] b);
		if (!a[OW]) return b;
		if (!b[OW]) return a;
		return (a[OW-1:0] <= b[OW-1:0]) ? a : b;
	endfunction

	function automatic logic [31:0] sat_ov(logic [OW-1:0] v);
		return (v > OW'(msdp_pkg::DIST_MAX)) ? msdp_pkg::DIST_MAX : v[31:0];
	endfunction

	function automatic logic [31:0] sat_h(logic [FB-1:0] v);
		logic [XW-1:0] e;
		e = XW'(v);
		return (e > XW'(msdp_pkg::DIST_MAX)) ? msdp_pkg::DIST_MAX : e[31:0];
	endfunction

	function automatic logic [FB-1:0] div3(logic [FB-1:0] x);
		logic [2*FB-1:0] prod;
		logic [FB-1:0]   q0;
		logic [FB+1:0]   rem;
		prod = {{FB{1'b0}}, x} * {{FB{1'b0}}, msdp_pkg::RECIP3};
		q0 = prod[2*FB-1:FB];
		rem = {2'b00, x} - ({2'b00, q0} + {1'b0, q0, 1'b0});
		return (rem >= (FB+2)'(3)) ? q0 + FB'(1) : q0;
	endfunction

	function automatic msdp_pkg::stage_t load_fn(logic signed [31:0] x,
		logic signed [31:0] y, logic signed [31:0] z);
		msdp_pkg::stage_t s;
		for (int i = 0; i < 4; i++) begin
			s.ov[i] = '0;
			s.r[i] = '0;
			s.gap[i] = '0;
		end
		s.c[0] = {{(CW-32){x[31]}}, x} + msdp_pkg::HALF_C;
		s.c[1] = {{(CW-32){y[31]}}, y} + msdp_pkg::HALF_C;
		s.c[2] = {{(CW-32){z[31]}}, z} + msdp_pkg::HALF_C;
		s.c[3] = msdp_pkg::THREE_HALF_C + {{(CW-32){x[31]}}, x}
			- {{(CW-32){y[31]}}, y} - {{(CW-32){z[31]}}, z} - msdp_pkg::HALF_C;
		s.viol = '0;
		s.hole = '0;
		s.done = 1'b0;
		s.solid = 1'b1;
		s.odist = '0;
		s.hdist = '0;
		s.lvl = '0;
		return s;
	endfunction

	function automatic msdp_pkg::stage_t box_fn(msdp_pkg::stage_t p);
		msdp_pkg::stage_t s;
		s = p;
		for (int i = 0; i < 4; i++) begin
			s.r[i] = p.c[i][FB-1:0];
			if (p.c[i] < 0) begin
				s.viol[i] = 1'b1;
				s.ov[i] = OW'(-p.c[i]);
			end else if (p.c[i] > msdp_pkg::ONE_C) begin
				s.viol[i] = 1'b1;
				s.ov[i] = OW'(p.c[i] - msdp_pkg::ONE_C);
			end else begin
				s.viol[i] = 1'b0;
				s.ov[i] = '0;
			end
		end
		return s;
	endfunction

	function automatic msdp_pkg::stage_t boxmin_fn(msdp_pkg::stage_t p);
		msdp_pkg::stage_t s;
		logic [OW:0] m01;
		logic [OW:0] m23;
		logic [OW:0] m;
		s = p;
		m01 = pick({p.viol[0], p.ov[0]}, {p.viol[1], p.ov[1]});
		m23 = pick({p.viol[2], p.ov[2]}, {p.viol[3], p.ov[3]});
		m = pick(m01, m23);
		if (m[OW]) begin
			s.done = 1'b1;
			s.solid = 1'b0;
			s.odist = sat_ov(m[OW-1:0]);
		end
		return s;
	endfunction

	function automatic msdp_pkg::stage_t digit_fn(msdp_pkg::stage_t p);
		msdp_pkg::stage_t s;
		logic [FB+1:0] a;
		logic [FB-1:0] frac;
		logic [FB-1:0] comp;
		s = p;
		for (int i = 0; i < 4; i++) begin
			a = {2'b00, p.r[i]} + {1'b0, p.r[i], 1'b0};
			frac = a[FB-1:0];
			comp = ~frac + FB'(1);
			s.r[i] = frac;
			s.hole[i] = (a[FB+1:FB] == 2'd1) && (frac != '0);
			s.gap[i] = (frac < comp) ? frac : comp;
		end
		return s;
	endfunction

	function automatic msdp_pkg::stage_t hole_fn(msdp_pkg::stage_t p,
		msdp_pkg::lvl_t m);
		msdp_pkg::stage_t s;
		logic [FB-1:0] best;
		logic          have;
		s = p;
		best = '0;
		have = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (p.hole[i] && (!have || p.gap[i] < best)) begin
				best = p.gap[i];
				have = 1'b1;
			end
		end
		if (!p.done && $countones(p.hole) >= 2) begin
			s.done = 1'b1;
			s.solid = 1'b0;
			s.lvl = m;
			s.hdist = best;
		end
		return s;
	endfunction

	function automatic msdp_pkg::stage_t div_fn(msdp_pkg::stage_t p,
		msdp_pkg::lvl_t j);
		msdp_pkg::stage_t s;
		s = p;
		if (p.lvl >= j) s.hdist = div3(p.hdist);
		return s;
	endfunction

	assign adv[N] = out_ready;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			msdp_pkg::stage_t nxt;

			assign adv[k] = !vld_s[k] || adv[k+1];

			if (k == 0) begin : g_load
				always_comb begin
					nxt = load_fn(pos_x, pos_y, pos_z);
				end
			end else if (k == 1) begin : g_box
				always_comb begin
					nxt = box_fn(item_s[k-1]);
				end
			end else if (k == 2) begin : g_boxmin
				always_comb begin
					nxt = boxmin_fn(item_s[k-1]);
				end
			end else if (k < msdp_pkg::BOX_STAGES + msdp_pkg::LVL_STAGES) begin : g_lvl
				if ((k - msdp_pkg::BOX_STAGES) % 2 == 0) begin : g_digit
					always_comb begin
						nxt = digit_fn(item_s[k-1]);
					end
				end else begin : g_hole
					always_comb begin
						nxt = hole_fn(item_s[k-1],
							msdp_pkg::lvl_t'((k - msdp_pkg::BOX_STAGES) / 2 + 1));
					end
				end
			end else begin : g_div
				always_comb begin
					nxt = div_fn(item_s[k-1],
						msdp_pkg::lvl_t'(k - msdp_pkg::BOX_STAGES - msdp_pkg::LVL_STAGES + 1));
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					item_s[k] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready = adv[0];
	assign out_valid = vld_s[N-1];
	assign inside_solid = item_s[N-1].solid;
	assign distance_estimate = (item_s[N-1].lvl == '0) ? item_s[N-1].odist
		: sat_h(item_s[N-1].hdist);

	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_solid |-> distance_estimate == '0)
		else $error("solid point with non-zero distance");

	a_hole_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_s[N-1].lvl != '0 |-> !inside_solid && item_s[N-1].done)
		else $error("hole level recorded on a solid point");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

// ----- tb/sv/menger_sponge_distance_probe_unit_tb.sv -----
`timescale 1ns / 1ps

module menger_sponge_distance_probe_unit_tb;

	localparam longint FX_ONE = longint'(1) << msdp_pkg::FRAC_BITS;
	localparam longint FX_HALF = longint'(1) << (msdp_pkg::FRAC_BITS - 1);
	localparam int RANDOM_POINTS = 1500;
	localparam int LONG_HOLD = 250;

	typedef enum logic [1:0] {PK_OUTSIDE, PK_HOLE, PK_SOLID} probe_kind_t;
	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	typedef struct packed {
		logic        solid;
		logic [31:0] distance;
		probe_kind_t kind;
	} probe_result_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		bit                 wait_idle;
	} probe_point_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               out_valid;
	logic               out_ready;
	logic               inside_solid;
	logic [31:0]        distance_estimate;

	probe_point_t  pending_points [$];
	probe_result_t expected_results [$];

	logic in_took;
	int   accepted_count;
	int   result_count;
	int   mismatch_count;
	int   solid_count;
	int   hole_count;
	int   outside_count;
	int   burst_left;
	int   gap_left;
	int   hold_left;
	int   next_hold_at;
	int   mode_left;
	rx_mode_t rx_mode;

	menger_sponge_distance_probe_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inside_solid     (inside_solid),
		.distance_estimate(distance_estimate)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void keep_least(inout longint unsigned best, inout bit have,
			input longint unsigned cand);
		if (!have || cand < best) begin
			best = cand;
			have = 1'b1;
		end
	endfunction

	function automatic logic [31:0] saturate_dist(longint unsigned v);
		return (v > 64'(msdp_pkg::DIST_MAX)) ? msdp_pkg::DIST_MAX : v[31:0];
	endfunction

	function automatic probe_result_t predict_probe(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		longint c [4];
		longint unsigned a [4];
		bit band [4];
		longint unsigned best;
		longint unsigned scale;
		bit have;
		probe_result_t r;
		c[0] = longint'(px) + FX_HALF;
		c[1] = longint'(py) + FX_HALF;
		c[2] = longint'(pz) + FX_HALF;
		c[3] = 3 * FX_HALF + c[0] - c[1] - c[2];
		best = 0;
		have = 1'b0;
		r.solid = 1'b0;
		r.distance = '0;
		r.kind = PK_OUTSIDE;
		for (int i = 0; i < 4; i++) begin
			if (c[i] < 0)
				keep_least(best, have, longint'(-c[i]));
			else if (c[i] > FX_ONE)
				keep_least(best, have, longint'(c[i] - FX_ONE));
		end
		if (have) begin
			r.distance = saturate_dist(best);
			return r;
		end
		scale = 3;
		for (int m = 1; m < msdp_pkg::LEVELS; m++) begin
			for (int i = 0; i < 4; i++) begin
				a[i] = (longint'(c[i]) * scale) % longint'(3 * FX_ONE);
				band[i] = a[i] > longint'(FX_ONE) && a[i] < longint'(2 * FX_ONE);
			end
			for (int i = 0; i < 4; i++) begin
				for (int j = i + 1; j < 4; j++) begin
					if (band[i] && band[j]) begin
						keep_least(best, have, a[i] - longint'(FX_ONE));
						keep_least(best, have, longint'(2 * FX_ONE) - a[i]);
						keep_least(best, have, a[j] - longint'(FX_ONE));
						keep_least(best, have, longint'(2 * FX_ONE) - a[j]);
					end
				end
			end
			if (have) begin
				r.kind = PK_HOLE;
				r.distance = saturate_dist(best / scale);
				return r;
			end
			scale *= 3;
		end
		r.solid = 1'b1;
		r.kind = PK_SOLID;
		return r;
	endfunction

	// coordinate built from base-3 digits 0 and 2, so it stays out of the hole band
	function automatic longint cantor_coord();
		longint v;
		longint p;
		v = 0;
		p = FX_ONE;
		for (int k = 0; k < 10; k++) begin
			p = p / 3;
			if ($urandom_range(0, 1))
				v += 2 * p;
		end
		return v;
	endfunction

	function automatic longint near_box_coord();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return longint'($urandom_range(0, 4)) - 2;
		if (pick == 1)
			return FX_ONE + longint'($urandom_range(0, 4)) - 2;
		return longint'($urandom_range(0, 32'(FX_ONE * 3 / 2))) - FX_ONE / 4;
	endfunction

	task automatic add_point(longint x, longint y, longint z, bit wait_idle);
		probe_point_t p;
		p.x = 32'(x);
		p.y = 32'(y);
		p.z = 32'(z);
		p.wait_idle = wait_idle;
		pending_points.push_back(p);
	endtask

	// input acceptance and result checking, both on the rising edge
	always @(posedge clk) begin
		probe_result_t want;
		probe_result_t got;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: inside %0d dist %h",
							inside_solid, distance_estimate);
				end else begin
					want = expected_results.pop_front();
					if (inside_solid !== want.solid || distance_estimate !== want.distance) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch on result %0d: inside exp %0d got %0d, dist exp %h got %h",
								result_count, want.solid, inside_solid, want.distance,
								distance_estimate);
					end
					result_count++;
				end
			end
			if (in_valid && in_ready) begin
				got = predict_probe(pos_x, pos_y, pos_z);
				expected_results.push_back(got);
				accepted_count++;
				case (got.kind)
					PK_SOLID: solid_count++;
					PK_HOLE: hole_count++;
					default: outside_count++;
				endcase
			end
		end
	end

	// driver: bursts of transactions with gaps, and a full drain where asked
	always @(negedge clk) begin
		logic offer;
		probe_point_t item;
		offer = in_valid && !in_took;
		if (arst_n && !offer) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_points.size() != 0 &&
					!(pending_points[0].wait_idle && expected_results.size() != 0)) begin
				item = pending_points.pop_front();
				pos_x <= item.x;
				pos_y <= item.y;
				pos_z <= item.z;
				offer = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 20);
					else
						gap_left = $urandom_range(1, 4);
				end
			end
		end
		in_valid <= offer;
	end

	// receiver: changing stall pattern, plus long hold-offs to back the pipeline up
	always @(negedge clk) begin
		logic rdy;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (accepted_count >= next_hold_at) begin
			hold_left = LONG_HOLD;
			next_hold_at += 700;
			rdy = 1'b0;
		end else begin
			if (mode_left <= 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
				RX_STEADY: rdy = 1'b1;
				RX_COIN: rdy = $urandom_range(0, 1);
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = ($urandom_range(0, 7) != 0);
			endcase
		end
		out_ready <= rdy;
	end

	initial begin
		int pick;
		longint cx;
		longint cy;
		longint cz;
		longint lo;
		longint hi;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		out_ready = 1'b0;
		in_took = 1'b0;
		accepted_count = 0;
		result_count = 0;
		mismatch_count = 0;
		solid_count = 0;
		hole_count = 0;
		outside_count = 0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		next_hold_at = 300;
		mode_left = 0;
		rx_mode = RX_STEADY;

		add_point(0, 0, 0, 1'b0);
		add_point(-FX_HALF, -FX_HALF, 0, 1'b0);
		add_point(FX_HALF, FX_HALF, 0, 1'b0);
		add_point(-FX_HALF - 1, -FX_HALF, 0, 1'b0);
		add_point(FX_HALF + 1, FX_HALF, 0, 1'b0);
		add_point(-FX_HALF, FX_HALF, FX_HALF, 1'b0);
		add_point(FX_HALF, -FX_HALF, -FX_HALF, 1'b0);
		add_point(-FX_HALF, -FX_HALF, -FX_HALF, 1'b0);
		add_point(FX_ONE / 6 - FX_HALF, FX_ONE / 6 - FX_HALF, 0, 1'b0);
		add_point(FX_ONE / 486 - FX_HALF, FX_ONE / 486 - FX_HALF, 0, 1'b0);
		add_point(FX_ONE / 4 - FX_HALF, FX_ONE / 4 - FX_HALF, 0, 1'b0);
		add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		add_point(1, -1, 0, 1'b0);
		add_point(-1, 1, -1, 1'b0);

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (pick < 55) begin
					cx = $urandom_range(0, 32'(FX_ONE));
					cy = $urandom_range(0, 32'(FX_ONE));
				end else begin
					cx = cantor_coord();
					cy = cantor_coord();
				end
				// keep w inside the unit interval
				lo = FX_HALF + cx - cy;
				if (lo < 0)
					lo = 0;
				hi = 3 * FX_HALF + cx - cy;
				if (hi > FX_ONE)
					hi = FX_ONE;
				cz = lo + $urandom_range(0, 32'(hi - lo));
				if (pick >= 55 && $urandom_range(0, 2) == 0)
					cz = cantor_coord();
				add_point(cx - FX_HALF, cy - FX_HALF, cz - FX_HALF, n == 0 || n == 700);
			end else if (pick < 85) begin
				add_point(near_box_coord() - FX_HALF, near_box_coord() - FX_HALF,
					near_box_coord() - FX_HALF, n == 0 || n == 700);
			end else begin
				add_point(longint'($signed($urandom())), longint'($signed($urandom())),
					longint'($signed($urandom())), n == 0 || n == 700);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (msdp_pkg::NUM_STAGES + 8) @(posedge clk);

		$display("probed %0d points (%0d solid, %0d in a hole, %0d outside the box), %0d results checked",
			accepted_count, solid_count, hole_count, outside_count, result_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results still awaited", mismatch_count,
				expected_results.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still awaited", expected_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
design/msdp_pkg.sv
design/menger_sponge_distance_probe_unit.sv
tb/sv/menger_sponge_distance_probe_unit_tb.sv
